// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the next-prime block.
// Each macro takes a label, a property expression (or an antecedent and a consequent) and a message.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define NPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NPT_ASSERT(lbl, prop, msg)
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/npt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npt_pkg
// Widths, prime table and square table shared by the next-prime block.
// ---------------------------------------------------------------------------
package npt_pkg;

  localparam int ValueW  = 15;
  localparam int PrimeW  = 16;
  localparam int PW      = 8;   // width of a table prime
  localparam int TableLen = 43;
  localparam int IdxW    = $clog2(TableLen + 1);
  localparam int CntW    = $clog2(PrimeW + 1);

  localparam logic [PW-1:0] TableMax = 8'd191;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  function automatic logic [PW-1:0] prime_at(input logic [IdxW-1:0] k);
    logic [PW-1:0] p;
    case (k)
      6'd0:  p = 8'd2;
      6'd1:  p = 8'd3;
      6'd2:  p = 8'd5;
      6'd3:  p = 8'd7;
      6'd4:  p = 8'd11;
      6'd5:  p = 8'd13;
      6'd6:  p = 8'd17;
      6'd7:  p = 8'd19;
      6'd8:  p = 8'd23;
      6'd9:  p = 8'd29;
      6'd10: p = 8'd31;
      6'd11: p = 8'd37;
      6'd12: p = 8'd41;
      6'd13: p = 8'd43;
      6'd14: p = 8'd47;
      6'd15: p = 8'd53;
      6'd16: p = 8'd59;
      6'd17: p = 8'd61;
      6'd18: p = 8'd67;
      6'd19: p = 8'd71;
      6'd20: p = 8'd73;
      6'd21: p = 8'd79;
      6'd22: p = 8'd83;
      6'd23: p = 8'd89;
      6'd24: p = 8'd97;
      6'd25: p = 8'd101;
      6'd26: p = 8'd103;
      6'd27: p = 8'd107;
      6'd28: p = 8'd109;
      6'd29: p = 8'd113;
      6'd30: p = 8'd127;
      6'd31: p = 8'd131;
      6'd32: p = 8'd137;
      6'd33: p = 8'd139;
      6'd34: p = 8'd149;
      6'd35: p = 8'd151;
      6'd36: p = 8'd157;
      6'd37: p = 8'd163;
      6'd38: p = 8'd167;
      6'd39: p = 8'd173;
      6'd40: p = 8'd179;
      6'd41: p = 8'd181;
      6'd42: p = 8'd191;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

  // Square of the table prime; 191*191 still fits 16 bits.
  function automatic logic [PrimeW-1:0] square_at(input logic [IdxW-1:0] k);
    logic [PW-1:0] p;
    p = prime_at(k);
    return PrimeW'({8'd0, p} * {8'd0, p});
  endfunction

endpackage

// ----- hw/rtl/npt_rem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npt_rem
// Restoring bit-serial remainder: 16-bit dividend by 8-bit divisor,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module npt_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [npt_pkg::PrimeW-1:0]  dividend,
  input  logic [npt_pkg::PW-1:0]      divisor,
  output npt_pkg::rem_stat_t          stat
);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [npt_pkg::CntW-1:0]    cnt_r, cnt_nxt;
  logic [npt_pkg::PrimeW-1:0]  dvd_r, dvd_nxt;
  logic [npt_pkg::PW-1:0]      dsr_r, dsr_nxt;
  logic [npt_pkg::PW-1:0]      rem_r, rem_nxt;
  logic [npt_pkg::PW:0]        trial;

  assign trial = {rem_r, dvd_r[npt_pkg::PrimeW-1]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // subtract when the shifted partial remainder reaches the divisor
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = npt_pkg::PW'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = npt_pkg::PW'(trial);
      end
      dvd_nxt = {dvd_r[npt_pkg::PrimeW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == npt_pkg::CntW'(npt_pkg::PrimeW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

// ----- hw/rtl/next_prime_trial_division.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// next_prime_trial_division
// Smallest prime at or above a 15-bit value, by table lookup up to 191 and
// trial division by the table primes above that.
// ---------------------------------------------------------------------------
// channel   ports                     beat taken when
// input     start, busy, in_value     start && !busy
// result    out_valid, out_prime      out_valid (one cycle, no stall)
//
// Values up to 191 are found by a scan of the prime table. Larger values are
// tested candidate by candidate: each table prime whose square does not
// exceed the candidate divides it in the shared serial remainder unit, and a
// zero remainder moves on to the next candidate, up to the next prime.
// Synchronous active-low reset returns the sequencer to idle.
// busy stays high from the accepted beat until the result cycle.
module next_prime_trial_division (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [npt_pkg::ValueW-1:0]  in_value,
  output logic                        out_valid,
  output logic [npt_pkg::PrimeW-1:0]  out_prime
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TEST,
    ST_WAIT
  } state_t;

  state_t                      state_r;
  logic [npt_pkg::IdxW-1:0]    k_r;
  logic [npt_pkg::PrimeW-1:0]  cand_r;
  logic                        out_valid_r;
  logic [npt_pkg::PrimeW-1:0]  out_prime_r;
  logic                        div_go;
  npt_pkg::rem_stat_t          div_stat;
  logic [npt_pkg::PW-1:0]      cur_p;

  assign cur_p  = npt_pkg::prime_at(k_r);
  assign div_go = (state_r == ST_TEST) && (k_r != npt_pkg::IdxW'(npt_pkg::TableLen)) &&
                  (npt_pkg::square_at(k_r) <= cand_r);

  npt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (cand_r),
    .divisor  (cur_p),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            k_r    <= '0;
            cand_r <= {1'b0, in_value};
            if ({1'b0, in_value} <= {8'd0, npt_pkg::TableMax}) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_TEST;
            end
          end
        end
        ST_SCAN: begin
          // first table prime at or above the value
          if ({8'd0, cur_p} >= cand_r) begin
            out_prime_r <= {8'd0, cur_p};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_TEST: begin
          if (div_go) begin
            state_r <= ST_WAIT;
          end else begin
            // p*p past the candidate, or primes used up: prime
            out_prime_r <= cand_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            if (div_stat.zero) begin
              cand_r <= cand_r + 1'b1;
              k_r    <= '0;
            end else begin
              k_r <= k_r + 1'b1;
            end
            state_r <= ST_TEST;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;

`include "assert_macros.svh"

  `NPT_ASSERT(a_result_idle, !out_valid || !busy, "result beat while busy")
  `NPT_ASSERT_NEXT(a_single_beat, out_valid, !out_valid, "result held over two cycles")
  `NPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `NPT_ASSERT(a_prime_floor, !out_valid || (out_prime >= 16'd2), "result below two")
  `NPT_ASSERT(a_div_in_wait, !div_stat.done || (state_r == ST_WAIT), "remainder done outside wait")

endmodule
